// ----- src/ppm_see_pkg.sv -----
// shared types, codes and constants of the secondary escape estimator
package ppm_see_pkg;

   localparam int FREQ_BITS_DEF = 7;
   localparam int FREQ_MAX_DEF = 16384;

   localparam int NCTX = 352;
   localparam int CTX_INDEX_W = 9;
   localparam int ROW_W = 6;
   localparam logic [CTX_INDEX_W-1:0] RESERVED_INDEX = 9'd344;
   localparam logic [8:0] RESERVED_SYMBOLS = 9'd256;
   localparam logic [12:0] ESC_TOTAL_FACTOR = 13'd11;
   localparam logic [7:0] INIT_COUNT = 8'd16;

   localparam int DIVIDEND_W = 16;
   localparam int DIVISOR_W = 9;

   localparam logic [15:0] BIN_ESC_TABLE [16] = '{
      16'h3CDD, 16'h1F3F, 16'h59BF, 16'h48F3, 16'h5FFB, 16'h5545, 16'h63D1, 16'h5D9D,
      16'h64A1, 16'h5ABC, 16'h6632, 16'h6051, 16'h68F6, 16'h549B, 16'h6BCA, 16'h3AB0
   };

   typedef enum logic [1:0] {
      REQ_ESCAPE = 2'd0,
      REQ_UPDATE = 2'd1,
      REQ_BINARY = 2'd2,
      REQ_INIT   = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      S_BOOT_CLEAR,
      S_IDLE,
      S_ESC_INDEX,
      S_ESC_READ,
      S_ESC_WRITE,
      S_UPD_READ,
      S_UPD_WRITE,
      S_BIN_START,
      S_BIN_WAIT,
      S_INIT_CLEAR
   } state_type;

   typedef enum logic [1:0] {
      WR_CLEAR,
      WR_ESCAPE,
      WR_UPDATE
   } wr_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_ESCAPE,
      RES_BINARY
   } res_sel_type;

   typedef struct packed {
      logic [15:0] sum;
      logic [3:0]  shift;
      logic [7:0]  count;
   } ctx_entry_type;

   typedef struct packed {
      logic        load;
      logic        sel_load;
      logic        clear;
      logic        rd_en;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        div_start;
      logic        respond;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic clr_last;
   } status_type;

endpackage

// ----- src/ppm_see_div.sv -----
// restoring divider, one quotient bit per cycle
module ppm_see_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ppm_see_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [ppm_see_pkg::DIVISOR_W-1:0]  divisor,
   output logic [ppm_see_pkg::DIVIDEND_W-1:0] quotient,
   output logic                              done
);
   import ppm_see_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] shreg_ff, shreg_in;
   logic [DIVISOR_W-1:0]  dvsr_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic                  qbit;

   // dividend bits leave at the top while quotient bits enter at the bottom
   always_comb begin
      trial = {rem_ff, shreg_ff[DIVIDEND_W-1]};
      qbit = (trial >= {1'b0, dvsr_ff});
      rem_in = rem_ff;
      shreg_in = shreg_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = done_ff;
      if (start) begin
         rem_in = '0;
         shreg_in = dividend;
         cnt_in = CNT_W'(DIVIDEND_W - 1);
         run_in = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         rem_in = qbit ? DIVISOR_W'(trial - {1'b0, dvsr_ff}) : trial[DIVISOR_W-1:0];
         shreg_in = {shreg_ff[DIVIDEND_W-2:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shreg_ff <= shreg_in;
      if (start) begin
         dvsr_ff <= divisor;
      end
   end

   assign quotient = shreg_ff;
   assign done = done_ff;

endmodule

// ----- src/ppm_see_datapath.sv -----
// context memory, entry selection, escape estimate, context aging and binary mean
module ppm_see_datapath #(
   parameter int FREQ_BITS = ppm_see_pkg::FREQ_BITS_DEF,
   parameter int FREQ_MAX = ppm_see_pkg::FREQ_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ppm_see_pkg::cmd_type     cmd,
   output ppm_see_pkg::status_type  status,
   input  logic [7:0]               req_diff,
   input  logic [7:0]               req_masked_count,
   input  logic [8:0]               req_symbol_count,
   input  logic [8:0]               req_prev_symbol_count,
   input  logic [15:0]              req_total_freq,
   input  logic [7:0]               req_first_freq,
   input  logic                     req_prev_success,
   output logic [15:0]              rsp_value
);
   import ppm_see_pkg::*;

   localparam logic [3:0] INIT_SHIFT = 4'(FREQ_BITS - 3);
   localparam logic [3:0] SHIFT_LIMIT = 4'(FREQ_BITS);
   localparam logic [15:0] FREQ_MAX_W = 16'(FREQ_MAX);

   // latched request beat
   logic [7:0]  diff_ff;
   logic [7:0]  masked_ff;
   logic [8:0]  sym_ff;
   logic [8:0]  prev_ff;
   logic [15:0] tot_ff;
   logic [7:0]  ffreq_ff;
   logic        psucc_ff;

   logic [CTX_INDEX_W-1:0] last_sel_ff, last_sel_in;
   logic [CTX_INDEX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [15:0]            value_ff, value_in;

   ctx_entry_type mem [0:NCTX-1];
   ctx_entry_type rd_ff;
   ctx_entry_type wr_data;
   ctx_entry_type clr_entry, esc_entry, upd_entry;
   logic [CTX_INDEX_W-1:0] mem_addr;

   logic [ROW_W-1:0]       row;
   logic                   col2, col1, col0;
   logic [12:0]            sym_scaled;
   logic [CTX_INDEX_W-1:0] sel_index;
   logic [ROW_W-1:0]       clr_row;
   logic [31:0]            clr_sum;
   logic [15:0]            esc_q, esc_value;
   logic [7:0]             cnt_dec;
   logic [3:0]             nshift;
   logic [15:0]            cnt_wide;
   logic [8:0]             n_eff;
   logic [3:0]             cls, bin_col;
   logic [DIVIDEND_W-1:0]  quotient;
   logic                   div_done;
   logic [15:0]            scale;
   logic [16:0]            mean;
   logic [15:0]            bin_value;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         diff_ff <= req_diff;
         masked_ff <= req_masked_count;
         sym_ff <= req_symbol_count;
         prev_ff <= req_prev_symbol_count;
         tot_ff <= req_total_freq;
         ffreq_ff <= req_first_freq;
         psucc_ff <= req_prev_success;
      end
   end

   // diff bucket and compare bits
   always_comb begin
      if (diff_ff < 8'd4) begin
         row = ROW_W'(diff_ff);
      end else if (diff_ff < 8'd12) begin
         row = ROW_W'(8'd4 + ((diff_ff - 8'd4) >> 1));
      end else if (diff_ff < 8'd44) begin
         row = ROW_W'(8'd8 + ((diff_ff - 8'd12) >> 2));
      end else begin
         row = ROW_W'(8'd16 + ((diff_ff - 8'd44) >> 3));
      end
      col2 = (({2'b00, diff_ff} + {1'b0, sym_ff}) < {1'b0, prev_ff});
      sym_scaled = 13'(sym_ff) * ESC_TOTAL_FACTOR;
      col1 = (tot_ff < {3'b000, sym_scaled});
      col0 = (masked_ff > diff_ff);
      sel_index = (sym_ff == RESERVED_SYMBOLS) ? RESERVED_INDEX : {row, col2, col1, col0};
   end

   always_comb begin
      last_sel_in = cmd.sel_load ? sel_index : last_sel_ff;
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clear && cmd.wr_en) begin
         clr_cnt_in = status.clr_last ? '0 : clr_cnt_ff + CTX_INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sel_ff <= '0;
         clr_cnt_ff <= '0;
      end else begin
         last_sel_ff <= last_sel_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign status.clr_last = (clr_cnt_ff == CTX_INDEX_W'(NCTX - 1));
   assign mem_addr = cmd.clear ? clr_cnt_ff : last_sel_ff;

   // reload value of the swept entry
   always_comb begin
      clr_row = clr_cnt_ff[CTX_INDEX_W-1:3];
      clr_sum = ((32'(clr_row) << 2) + 32'd8) << (FREQ_BITS - 3);
      clr_entry.sum = clr_sum[15:0];
      clr_entry.shift = INIT_SHIFT;
      clr_entry.count = INIT_COUNT;
   end

   always_comb begin
      esc_q = rd_ff.sum >> rd_ff.shift;
      esc_entry = rd_ff;
      esc_entry.sum = rd_ff.sum - esc_q;
      esc_value = (esc_q == 16'd0) ? 16'd1 : esc_q;
   end

   // aging below the shift limit: count down, double the sum and raise the shift when the count runs out
   always_comb begin
      upd_entry = rd_ff;
      cnt_dec = rd_ff.count - 8'd1;
      nshift = rd_ff.shift + 4'd1;
      cnt_wide = 16'd2 << nshift;
      if (rd_ff.shift < SHIFT_LIMIT) begin
         upd_entry.count = cnt_dec;
         if (cnt_dec == 8'd0) begin
            upd_entry.sum = {rd_ff.sum[14:0], 1'b0};
            upd_entry.shift = nshift;
            upd_entry.count = cnt_wide[7:0];
         end
      end
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_CLEAR:  wr_data = clr_entry;
         WR_ESCAPE: wr_data = esc_entry;
         WR_UPDATE: wr_data = upd_entry;
         default:   wr_data = clr_entry;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[mem_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // binary table column from parent count class
   always_comb begin
      n_eff = (prev_ff == 9'd0) ? 9'd1 : prev_ff;
      if (n_eff <= 9'd6) begin
         cls = {n_eff[2:0], 1'b0} - 4'd2;
      end else if (n_eff <= 9'd50) begin
         cls = 4'd12;
      end else begin
         cls = 4'd14;
      end
      bin_col = cls + {3'b000, psucc_ff};
   end

   ppm_see_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (BIN_ESC_TABLE[bin_col]),
      .divisor  ({1'b0, ffreq_ff} + 9'd1),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.div_done = div_done;

   always_comb begin
      scale = (FREQ_MAX_W > quotient) ? FREQ_MAX_W - quotient : 16'd0;
      mean = ({1'b0, scale} + 17'd32) >> 7;
      bin_value = (mean > 17'd255) ? 16'd255 : mean[15:0];
   end

   always_comb begin
      value_in = value_ff;
      if (cmd.respond) begin
         case (cmd.res_sel)
            RES_ESCAPE: value_in = esc_value;
            RES_BINARY: value_in = bin_value;
            RES_ZERO:   value_in = 16'd0;
            default:    value_in = 16'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign rsp_value = value_ff;

endmodule

// ----- src/ppm_see_ctrl.sv -----
// request sequencer of the secondary escape estimator
module ppm_see_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_type,
   input  ppm_see_pkg::status_type status,
   output ppm_see_pkg::cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);
   import ppm_see_pkg::*;

   state_type state_ff, state_in;
   logic      strobe_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_BOOT_CLEAR: begin
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               case (req_code_type'(req_type))
                  REQ_ESCAPE: state_in = S_ESC_INDEX;
                  REQ_UPDATE: state_in = S_UPD_READ;
                  REQ_BINARY: state_in = S_BIN_START;
                  REQ_INIT:   state_in = S_INIT_CLEAR;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_ESC_INDEX: state_in = S_ESC_READ;
         S_ESC_READ:  state_in = S_ESC_WRITE;
         S_ESC_WRITE: state_in = S_IDLE;
         S_UPD_READ:  state_in = S_UPD_WRITE;
         S_UPD_WRITE: state_in = S_IDLE;
         S_BIN_START: state_in = S_BIN_WAIT;
         S_BIN_WAIT: begin
            if (status.div_done) state_in = S_IDLE;
         end
         S_INIT_CLEAR: begin
            if (status.clr_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.wr_sel = WR_CLEAR;
      cmd.res_sel = RES_ZERO;
      busy = 1'b1;
      case (state_ff)
         S_BOOT_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.wr_en = 1'b1;
         end
         S_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         S_ESC_INDEX: cmd.sel_load = 1'b1;
         S_ESC_READ:  cmd.rd_en = 1'b1;
         S_ESC_WRITE: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_ESCAPE;
            cmd.respond = 1'b1;
            cmd.res_sel = RES_ESCAPE;
         end
         S_UPD_READ: cmd.rd_en = 1'b1;
         S_UPD_WRITE: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_UPDATE;
            cmd.respond = 1'b1;
         end
         S_BIN_START: cmd.div_start = 1'b1;
         S_BIN_WAIT: begin
            cmd.respond = status.div_done;
            cmd.res_sel = RES_BINARY;
         end
         S_INIT_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.wr_en = 1'b1;
            cmd.respond = status.clr_last;
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BOOT_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= cmd.respond;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

// ----- src/ppm_secondary_escape_estimator.sv -----
// top level of the secondary escape estimator: sequencer plus datapath
// steps to rsp_strobe: escape index, read, write; update read, write; binary mean starts
// the divider and waits for done; reinitialize writes one context per cycle over 352 entries
// one beat at a time; busy stays high until the result register is loaded
// reset: synchronous, then a clearing pass over all 352 entries with busy high before the first beat
// the receiver cannot stall: rsp_strobe marks rsp_value for exactly one cycle
module ppm_secondary_escape_estimator #(
   parameter int FREQ_BITS = ppm_see_pkg::FREQ_BITS_DEF,
   parameter int FREQ_MAX = ppm_see_pkg::FREQ_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_diff,
   input  logic [7:0]  req_masked_count,
   input  logic [8:0]  req_symbol_count,
   input  logic [8:0]  req_prev_symbol_count,
   input  logic [15:0] req_total_freq,
   input  logic [7:0]  req_first_freq,
   input  logic        req_prev_success,
   output logic        rsp_strobe,
   output logic [15:0] rsp_value
);
   import ppm_see_pkg::*;

   cmd_type    cmd;
   status_type status;

   ppm_see_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ppm_see_datapath #(
      .FREQ_BITS (FREQ_BITS),
      .FREQ_MAX  (FREQ_MAX)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_diff              (req_diff),
      .req_masked_count      (req_masked_count),
      .req_symbol_count      (req_symbol_count),
      .req_prev_symbol_count (req_prev_symbol_count),
      .req_total_freq        (req_total_freq),
      .req_first_freq        (req_first_freq),
      .req_prev_success      (req_prev_success),
      .rsp_value             (rsp_value)
   );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the ppm secondary escape estimator
`timescale 1ns / 100ps

module tb_top;
   import ppm_see_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 400;

   typedef struct {
      req_code_type kind;
      logic [7:0]   diff;
      logic [7:0]   masked_count;
      logic [8:0]   symbol_count;
      logic [8:0]   prev_symbol_count;
      logic [15:0]  total_freq;
      logic [7:0]   first_freq;
      logic         prev_success;
   } see_request_type;

   class escape_estimator_sb_type;
      logic [15:0] ctx_sum [NCTX];
      logic [3:0]  ctx_shift [NCTX];
      logic [7:0]  ctx_count [NCTX];
      logic [8:0]  last_entry;
      logic [15:0] mean_q [$];
      int unsigned mismatches;

      function new();
         reload_contexts();
         last_entry = '0;
         mismatches = 0;
      endfunction

      function void reload_contexts();
         for (int k = 0; k < NCTX; k++) begin
            ctx_shift[k] = 4'(FREQ_BITS_DEF - 3);
            ctx_sum[k] = 16'((4 * (k / 8) + 8) << (FREQ_BITS_DEF - 3));
            ctx_count[k] = INIT_COUNT;
         end
      endfunction

      function int pending();
         return mean_q.size();
      endfunction

      // advance the context state by one beat and queue the value it must answer
      function void note_request(see_request_type r);
         logic [15:0] v;
         int k, col, row, d, q, n, cls, sub, scale, mean;
         v = '0;
         case (r.kind)
            REQ_ESCAPE: begin
               if (r.symbol_count == RESERVED_SYMBOLS) begin
                  k = RESERVED_INDEX;
               end else begin
                  d = r.diff;
                  col = 0;
                  if (d + int'(r.symbol_count) < int'(r.prev_symbol_count)) col += 4;
                  if (int'(r.total_freq) < int'(ESC_TOTAL_FACTOR) * int'(r.symbol_count))
                     col += 2;
                  if (r.masked_count > r.diff) col += 1;
                  if (d < 4) row = d;
                  else if (d < 12) row = 4 + ((d - 4) >> 1);
                  else if (d < 44) row = 8 + ((d - 12) >> 2);
                  else row = 16 + ((d - 44) >> 3);
                  k = row * 8 + col;
               end
               if (k >= NCTX) k = NCTX - 1;
               last_entry = 9'(k);
               q = int'(ctx_sum[k]) >> ctx_shift[k];
               ctx_sum[k] = 16'(int'(ctx_sum[k]) - q);
               v = (q == 0) ? 16'd1 : 16'(q);
            end
            REQ_UPDATE: begin
               k = last_entry;
               if (k < NCTX && ctx_shift[k] < FREQ_BITS_DEF) begin
                  ctx_count[k] = ctx_count[k] - 8'd1;
                  if (ctx_count[k] == 8'd0) begin
                     ctx_sum[k] = {ctx_sum[k][14:0], 1'b0};
                     ctx_shift[k] = ctx_shift[k] + 4'd1;
                     // shift 7 loads a zero count, which is harmless once saturated
                     ctx_count[k] = 8'(2 << ctx_shift[k]);
                  end
               end
            end
            REQ_BINARY: begin
               n = r.prev_symbol_count;
               if (n == 0) n = 1;
               if (n <= 6) cls = 2 * (n - 1);
               else if (n <= 50) cls = 12;
               else cls = 14;
               sub = int'(BIN_ESC_TABLE[(cls + int'(r.prev_success)) & 15])
                     / (int'(r.first_freq) + 1);
               scale = (FREQ_MAX_DEF > sub) ? FREQ_MAX_DEF - sub : 0;
               scale = scale & 16'hFFFF;
               mean = (scale + 32) >> 7;
               v = (mean > 255) ? 16'd255 : 16'(mean);
            end
            default: reload_contexts();
         endcase
         mean_q.push_back(v);
      endfunction

      function void check_value(logic [15:0] got);
         logic [15:0] want;
         if (mean_q.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected result beat, value %0d", $time, got);
            mismatches++;
         end else begin
            want = mean_q.pop_front();
            if (got !== want) begin
               if (mismatches < 10)
                  $display("%0t: value mismatch, expected %0d got %0d", $time, want, got);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_code_type req_type;
   logic [7:0]   req_diff;
   logic [7:0]   req_masked_count;
   logic [8:0]   req_symbol_count;
   logic [8:0]   req_prev_symbol_count;
   logic [15:0]  req_total_freq;
   logic [7:0]   req_first_freq;
   logic         req_prev_success;
   logic         rsp_strobe;
   logic [15:0]  rsp_value;

   escape_estimator_sb_type sb;
   int gap_pct;
   int beats_sent;
   int stall_run;

   ppm_secondary_escape_estimator uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_diff(req_diff),
      .req_masked_count(req_masked_count),
      .req_symbol_count(req_symbol_count),
      .req_prev_symbol_count(req_prev_symbol_count),
      .req_total_freq(req_total_freq),
      .req_first_freq(req_first_freq),
      .req_prev_success(req_prev_success),
      .rsp_strobe(rsp_strobe),
      .rsp_value(rsp_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) sb.check_value(rsp_value);
   end

   // ends the run when neither an input beat nor a result moves for too long
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_run <= 0;
      end else if (stall_run >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_run <= stall_run + 1;
      end
   end

   function automatic see_request_type mk(req_code_type kind, int diff, int masked, int sym,
                                          int prev, int tot, int ff, int ps);
      see_request_type r;
      r.kind = kind;
      r.diff = 8'(diff);
      r.masked_count = 8'(masked);
      r.symbol_count = 9'(sym);
      r.prev_symbol_count = 9'(prev);
      r.total_freq = 16'(tot);
      r.first_freq = 8'(ff);
      r.prev_success = 1'(ps);
      return r;
   endfunction

   // wild picks symbol count, parent count and first frequency over their full bit range
   function automatic see_request_type random_request(req_code_type kind, bit wild);
      see_request_type r;
      r.kind = kind;
      r.diff = $urandom_range(1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      r.masked_count = 8'($urandom);
      if (wild) r.symbol_count = 9'($urandom);
      else if ($urandom_range(9) == 0) r.symbol_count = RESERVED_SYMBOLS;
      else r.symbol_count = 9'($urandom_range(1, 255));
      if (wild) r.prev_symbol_count = 9'($urandom);
      else if ($urandom_range(2) == 0) r.prev_symbol_count = 9'($urandom_range(1, 8));
      else r.prev_symbol_count = 9'($urandom_range(1, 256));
      r.total_freq = $urandom_range(1) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
      r.first_freq = wild ? 8'($urandom) : 8'($urandom_range(1, 128));
      r.prev_success = 1'($urandom);
      return r;
   endfunction

   task automatic send_request(input see_request_type r);
      int gap;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         gap = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start <= 1'b1;
      req_type <= r.kind;
      req_diff <= r.diff;
      req_masked_count <= r.masked_count;
      req_symbol_count <= r.symbol_count;
      req_prev_symbol_count <= r.prev_symbol_count;
      req_total_freq <= r.total_freq;
      req_first_freq <= r.first_freq;
      req_prev_success <= r.prev_success;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(r);
      beats_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int n_beats);
      see_request_type r;
      int target, roll;
      target = beats_sent + n_beats;
      while (beats_sent < target) begin
         roll = $urandom_range(999);
         if (roll < 450) begin
            // usual coder pattern: escape estimate, then age the chosen entry
            r = random_request(REQ_ESCAPE, 1'b0);
            send_request(r);
            repeat ($urandom_range(0, 2)) begin
               r = random_request(REQ_UPDATE, 1'b0);
               send_request(r);
            end
         end else if (roll < 650) begin
            send_request(random_request(REQ_BINARY, 1'b0));
         end else if (roll < 730) begin
            send_request(random_request(REQ_UPDATE, 1'b0));
         end else if (roll < 745) begin
            send_request(random_request(REQ_INIT, 1'b0));
         end else if (roll < 765) begin
            // same entry over and over drains its sum toward the answer's floor of one
            r = random_request(REQ_ESCAPE, 1'b0);
            r.diff = 8'($urandom_range(0, 3));
            repeat ($urandom_range(20, 60)) send_request(r);
         end else if (roll < 770) begin
            // long aging run pushes one entry toward the top shift
            send_request(random_request(REQ_ESCAPE, 1'b0));
            repeat ($urandom_range(16, 220)) send_request(random_request(REQ_UPDATE, 1'b1));
         end else if (roll < 900) begin
            send_request(random_request(req_code_type'(2'($urandom)), 1'b1));
         end else begin
            r = random_request(REQ_ESCAPE, 1'b0);
            r.symbol_count = RESERVED_SYMBOLS;
            send_request(r);
            send_request(random_request(REQ_UPDATE, 1'b0));
         end
      end
   endtask

   initial begin
      sb = new();
      gap_pct = 0;
      beats_sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_ESCAPE;
      req_diff = '0;
      req_masked_count = '0;
      req_symbol_count = 9'd1;
      req_prev_symbol_count = 9'd1;
      req_total_freq = '0;
      req_first_freq = 8'd1;
      req_prev_success = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // binary mean: parent count zero, oversized parent, divisor edges, negative scale
      send_request(mk(REQ_BINARY, 0, 0, 1, 0, 0, 0, 0));
      send_request(mk(REQ_BINARY, 0, 0, 1, 511, 0, 255, 1));
      send_request(mk(REQ_BINARY, 0, 0, 1, 51, 0, 0, 0));
      send_request(mk(REQ_BINARY, 0, 0, 1, 6, 0, 128, 1));
      send_request(mk(REQ_BINARY, 0, 0, 1, 7, 0, 1, 0));
      send_request(mk(REQ_BINARY, 0, 0, 1, 50, 0, 1, 1));
      // escape: reserved entry, column bits, symbol count zero and above 256
      send_request(mk(REQ_ESCAPE, 0, 255, 256, 1, 0, 1, 0));
      send_request(mk(REQ_UPDATE, 0, 0, 1, 1, 0, 1, 0));
      send_request(mk(REQ_ESCAPE, 255, 0, 1, 256, 0, 1, 0));
      send_request(mk(REQ_ESCAPE, 0, 0, 1, 256, 65535, 1, 0));
      send_request(mk(REQ_ESCAPE, 3, 4, 0, 0, 0, 1, 0));
      send_request(mk(REQ_ESCAPE, 4, 255, 511, 511, 65535, 1, 1));
      send_request(mk(REQ_ESCAPE, 11, 0, 511, 0, 0, 1, 0));
      send_request(mk(REQ_ESCAPE, 12, 200, 255, 300, 100, 1, 0));
      send_request(mk(REQ_ESCAPE, 43, 44, 1, 100, 5, 1, 0));
      send_request(mk(REQ_ESCAPE, 44, 0, 2, 200, 21, 1, 0));
      send_request(mk(REQ_UPDATE, 0, 0, 1, 1, 0, 1, 0));
      send_request(mk(REQ_UPDATE, 0, 0, 1, 1, 0, 1, 0));
      send_request(mk(REQ_INIT, 0, 0, 1, 1, 0, 1, 0));
      send_request(mk(REQ_ESCAPE, 0, 255, 256, 1, 0, 1, 0));
      send_request(mk(REQ_UPDATE, 0, 0, 1, 1, 0, 1, 0));
      hold_until_drained();

      gap_pct = 12;
      run_phase(450);
      hold_until_drained();
      gap_pct = 45;
      run_phase(450);
      hold_until_drained();
      gap_pct = 0;
      run_phase(430);
      hold_until_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/ppm_see_pkg.sv
src/ppm_see_div.sv
src/ppm_see_datapath.sv
src/ppm_see_ctrl.sv
src/ppm_secondary_escape_estimator.sv
tb/tb_top.sv
